// ===== sv/esh_pkg.sv =====
package esh_pkg;

    localparam int          CACHE_DEPTH_DEF = 16;
    localparam logic [15:0] TTL_RESET       = 16'd1000;
    localparam logic [63:0] FNV_BASIS       = 64'hcbf29ce484222325;

    localparam logic [1:0] OP_CHECK  = 2'd0;
    localparam logic [1:0] OP_RECORD = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [47:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic        echo_seen;
        logic [63:0] payload_hash;
    } out_item_t;

    typedef struct packed {
        logic drop;
        logic shift;
        logic clear;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PURGE,
        ST_LOOKUP,
        ST_EMIT
    } state_t;

endpackage

// ===== sv/esh_hash.sv =====
module esh_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fold_en,
    input  logic        last_byte,
    input  logic [7:0]  data_byte,
    output logic [63:0] hash_fold
);
    import esh_pkg::*;

    logic [63:0] running_hash_reg;
    logic [63:0] running_hash_next;
    logic [63:0] mix;

    // The FNV prime is 2^40 + 0x1b3, so the product is a short sum of shifts.
    assign mix       = running_hash_reg ^ {56'd0, data_byte};
    assign hash_fold = (mix << 40) + (mix << 8) + (mix << 7) + (mix << 5)
                     + (mix << 4) + (mix << 1) + mix;

    always_comb begin
        running_hash_next = running_hash_reg;
        if (fold_en) begin
            running_hash_next = last_byte ? FNV_BASIS : hash_fold;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_hash_reg <= FNV_BASIS;
        end else begin
            running_hash_reg <= running_hash_next;
        end
    end

endmodule

// ===== sv/esh_cell.sv =====
module esh_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  esh_pkg::cell_cmd_t  cmd,
    input  logic [63:0]         key_hash,
    input  logic [47:0]         now_ms,
    input  logic [15:0]         ttl_ms,
    input  logic [63:0]         prev_hash,
    input  logic [47:0]         prev_time,
    input  logic                prev_valid,
    input  logic                next_valid,
    output logic [63:0]         hash_q,
    output logic [47:0]         time_q,
    output logic                valid_q,
    output logic                match,
    output logic                oldest_stale
);
    import esh_pkg::*;

    logic [63:0] hash_reg;
    logic [47:0] time_reg;
    logic        valid_reg;
    logic        valid_next;
    logic [48:0] age;
    logic        stale;

    // A borrow means time went backwards; such an entry counts as fresh.
    assign age          = {1'b0, now_ms} - {1'b0, time_reg};
    assign stale        = !age[48] && (age[47:0] > {32'd0, ttl_ms});
    assign oldest_stale = valid_reg && !next_valid && stale;
    assign match        = valid_reg && (hash_reg == key_hash);

    assign hash_q  = hash_reg;
    assign time_q  = time_reg;
    assign valid_q = valid_reg;

    always_comb begin
        valid_next = valid_reg;
        if (cmd.clear) begin
            valid_next = 1'b0;
        end else if (cmd.shift) begin
            valid_next = prev_valid;
        end else if (cmd.drop && oldest_stale) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.shift && !cmd.clear) begin
            hash_reg <= prev_hash;
            time_reg <= prev_time;
        end
    end

endmodule

// ===== sv/echo_suppress_hash_cache.sv =====
// Recent-payload filter. Payload bytes stream in one per cycle and fold into a
// running FNV-1a 64-bit hash; the request that carries the last byte produces
// one result with the final hash. The store is a chain of CACHE_DEPTH cells,
// newest entry in cell 0 and oldest at the end of the filled run; a record,
// or a check that finds no match, shifts the whole chain by one, dropping the
// oldest entry when full. After a last byte the input stalls through PURGE,
// LOOKUP and EMIT; a check purges up to CACHE_DEPTH stale entries, one per
// cycle from the oldest end, and EMIT holds while the previous result still
// sits untaken in the output register; the result then waits in that register
// while the next payload's bytes are taken. Entries older than ttl_ms (written
// through the cfg port, reset value 1000) are stale.
module echo_suppress_hash_cache #(
    parameter int CACHE_DEPTH = esh_pkg::CACHE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  esh_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output esh_pkg::out_item_t  m_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);
    import esh_pkg::*;

    state_t      state_reg;
    state_t      state_next;
    logic [15:0] ttl_reg;
    logic [1:0]  op_reg;
    logic [63:0] hash_reg;
    logic [47:0] now_reg;
    logic        seen_reg;
    logic        seen_next;
    logic        m_valid_reg;
    out_item_t   m_item_reg;
    logic        load_out;
    logic        in_accept;
    logic [63:0] hash_fold;
    cell_cmd_t   cmd;

    logic [63:0]            cell_hash [CACHE_DEPTH];
    logic [47:0]            cell_time [CACHE_DEPTH];
    logic [CACHE_DEPTH-1:0] cell_valid;
    logic [CACHE_DEPTH-1:0] cell_match;
    logic [CACHE_DEPTH-1:0] cell_stale;
    logic                   any_match;
    logic                   any_stale;

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;
    assign any_match = |cell_match;
    assign any_stale = |cell_stale;

    esh_hash u_hash (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fold_en   (in_accept),
        .last_byte (s_item.last_byte),
        .data_byte (s_item.data_byte),
        .hash_fold (hash_fold)
    );

    for (genvar i = 0; i < CACHE_DEPTH; i++) begin : g_cell
        logic [63:0] prev_hash;
        logic [47:0] prev_time;
        logic        prev_valid;
        logic        next_valid;

        if (i == 0) begin : g_head
            assign prev_hash  = hash_reg;
            assign prev_time  = now_reg;
            assign prev_valid = 1'b1;
        end else begin : g_body
            assign prev_hash  = cell_hash[i-1];
            assign prev_time  = cell_time[i-1];
            assign prev_valid = cell_valid[i-1];
        end

        if (i == CACHE_DEPTH - 1) begin : g_tail
            assign next_valid = 1'b0;
        end else begin : g_inner
            assign next_valid = cell_valid[i+1];
        end

        esh_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .cmd          (cmd),
            .key_hash     (hash_reg),
            .now_ms       (now_reg),
            .ttl_ms       (ttl_reg),
            .prev_hash    (prev_hash),
            .prev_time    (prev_time),
            .prev_valid   (prev_valid),
            .next_valid   (next_valid),
            .hash_q       (cell_hash[i]),
            .time_q       (cell_time[i]),
            .valid_q      (cell_valid[i]),
            .match        (cell_match[i]),
            .oldest_stale (cell_stale[i])
        );
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        seen_next  = seen_reg;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept && s_item.last_byte) begin
                    state_next = ST_PURGE;
                end
            end
            ST_PURGE: begin
                // Only check requests purge; the oldest stale cell drops each cycle.
                if (op_reg == OP_CHECK && any_stale) begin
                    cmd.drop = 1'b1;
                end else begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                seen_next  = 1'b0;
                state_next = ST_EMIT;
                case (op_reg)
                    OP_CHECK: begin
                        seen_next = any_match;
                        cmd.shift = !any_match;
                    end
                    OP_RECORD: begin
                        cmd.shift = 1'b1;
                    end
                    OP_CLEAR: begin
                        cmd.clear = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ttl_reg     <= TTL_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                ttl_reg <= cfg_data;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        seen_reg <= seen_next;
        if (in_accept && s_item.last_byte) begin
            op_reg   <= s_item.operation;
            now_reg  <= s_item.now_ms;
            hash_reg <= hash_fold;
        end
        if (load_out) begin
            m_item_reg.echo_seen    <= seen_reg;
            m_item_reg.payload_hash <= hash_reg;
        end
    end

`ifndef NO_ASSERTIONS
    // Filled cells always form one run that starts at the head of the chain.
    a_valid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        ((cell_valid + 1'b1) & cell_valid) == '0)
        else $error("cache cells do not form a contiguous run");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOKUP && op_reg == OP_CLEAR) |=> (cell_valid == '0))
        else $error("clear request left entries in the cache");

    a_record_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOKUP && op_reg == OP_RECORD)
            |=> (cell_valid[0] && cell_hash[0] == $past(hash_reg)))
        else $error("recorded hash missing from the head cell");

    a_no_input_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PURGE || state_reg == ST_LOOKUP) |=> !$past(in_accept))
        else $error("input accepted during cache processing");
`endif

endmodule
